FILE: hdl/midi_cc_parameter_curve_map_macros.svh
// Assertion helpers used by midi_cc_parameter_curve_map.
`ifndef MIDI_CC_PARAMETER_CURVE_MAP_MACROS_SVH
`define MIDI_CC_PARAMETER_CURVE_MAP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define PCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define PCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pcm_pkg.sv
`default_nettype none
package pcm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TAB_DEPTH = 256;
    localparam int ROM_SLOTS = 17;
    localparam logic [16:0] ONE_NORM = 17'h10000;
    localparam logic [63:0] Q30 = 64'h4000_0000;
    localparam logic [63:0] LOG10_2_Q32 = 64'd1292913986;

    typedef logic [16:0] t_norm;
    typedef logic [31:0] t_q16;
    typedef logic [5:0]  t_slot;

    localparam logic [1:0] CMD_CC  = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_RDS = 2'd2;
    localparam logic [1:0] CMD_RDN = 2'd3;

    localparam logic [1:0] TAPER_LIN = 2'd0;
    localparam logic [1:0] TAPER_LOG = 2'd1;
    localparam logic [1:0] TAPER_SQ  = 2'd2;
    localparam logic [1:0] TAPER_EXP = 2'd3;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [1:0]  taper;
    } t_desc;

    typedef logic [16:0] t_log_tab [0:256];
    typedef logic [31:0] t_exp_tab [0:256];
    typedef logic [35:0] t_expk_tab [0:16];
    typedef logic [16:0] t_cc_tab [0:127];

    // Per-slot taper descriptor; slots past the list are linear 0..0.
    function automatic t_desc f_desc(input t_slot s);
        t_desc d;
        d = '0;
        case (s)
            6'd0:  d = '{32'd0, 32'd65536, TAPER_SQ};
            6'd1:  d = '{32'd100 << 16, 32'd20000 << 16, TAPER_LOG};
            6'd2:  d = '{32'd0, 32'd32768, TAPER_LIN};
            6'd3:  d = '{32'd3277, 32'd32768, TAPER_LIN};
            6'd4:  d = '{32'd6554, 32'd2000 << 16, TAPER_LOG};
            6'd5:  d = '{32'd65536, 32'd5000 << 16, TAPER_LOG};
            6'd6:  d = '{32'd20 << 16, 32'd18000 << 16, TAPER_EXP};
            6'd7:  d = '{32'd0, 32'd65536, TAPER_LIN};
            6'd8:  d = '{32'd6554, 32'd5 << 16, TAPER_LOG};
            6'd9:  d = '{32'd0, 32'd2 << 16, TAPER_LIN};
            6'd10: d = '{32'd0, 32'd65536, TAPER_LIN};
            6'd11: d = '{32'd0, 32'd65536, TAPER_LIN};
            6'd12: d = '{32'd200 << 16, 32'd12000 << 16, TAPER_EXP};
            6'd13: d = '{32'd0, 32'd65536, TAPER_LIN};
            6'd14: d = '{32'd65536, 32'd1000 << 16, TAPER_SQ};
            6'd15: d = '{32'd0, 32'd62259, TAPER_LIN};
            6'd16: d = '{32'd0, 32'd65536, TAPER_LIN};
            default: d = '0;
        endcase
        return d;
    endfunction

    // Reset value of each parameter slot.
    function automatic t_norm f_default(input t_slot s);
        t_norm v;
        v = '0;
        case (s)
            6'd0:  v = 17'd65536;
            6'd1:  v = 17'd7130;
            6'd2:  v = 17'd26214;
            6'd3:  v = 17'd21845;
            6'd5:  v = 17'd340;
            6'd6:  v = 17'd57723;
            6'd7:  v = 17'd32768;
            6'd8:  v = 17'd3833;
            6'd9:  v = 17'd32768;
            6'd11: v = 17'd58982;
            6'd12: v = 17'd51523;
            6'd13: v = 17'd32768;
            6'd14: v = 17'd20631;
            6'd15: v = 17'd34493;
            6'd16: v = 17'd16384;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Controller number to slot + 1, zero when unmapped.
    function automatic t_slot f_cc_map(input logic [6:0] n);
        t_slot e;
        e = '0;
        case (n)
            7'd1:  e = 6'd17;
            7'd14: e = 6'd1;
            7'd15: e = 6'd2;
            7'd16: e = 6'd3;
            7'd17: e = 6'd4;
            7'd18: e = 6'd5;
            7'd19: e = 6'd6;
            7'd20: e = 6'd7;
            7'd21: e = 6'd8;
            7'd22: e = 6'd9;
            7'd23: e = 6'd10;
            7'd24: e = 6'd11;
            7'd25: e = 6'd15;
            7'd26: e = 6'd12;
            7'd27: e = 6'd13;
            7'd28: e = 6'd14;
            7'd29: e = 6'd16;
            default: e = '0;
        endcase
        return e;
    endfunction

    // Restoring divide, elaboration only.
    function automatic logic [63:0] f_div(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[62:0], n[k]};
            if (r >= d) begin
                r = r - d;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bq;
        v = v_in;
        res = '0;
        bq = 64'd1 << 62;
        while (bq > v) bq = bq >> 2;
        while (bq != 0) begin
            if (v >= res + bq) begin
                v = v - (res + bq);
                res = (res >> 1) + bq;
            end else begin
                res = res >> 1;
            end
            bq = bq >> 2;
        end
        return res;
    endfunction

    // log2(n/d) in Q.30 for n >= d > 0.
    function automatic logic [63:0] f_log2_ratio(input logic [63:0] n, input logic [63:0] d_in);
        logic [63:0] d;
        logic [63:0] ip;
        logic [63:0] fr;
        logic [63:0] m;
        d = d_in;
        ip = '0;
        fr = '0;
        if (d == 0 || n < d) return 64'd0;
        while (n >= (d << 1)) begin
            d = d << 1;
            ip = ip + 64'd1;
        end
        m = f_div(n << 30, d);
        for (int k = 29; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= (Q30 << 1)) begin
                m = m >> 1;
                fr[k] = 1'b1;
            end
        end
        return (ip << 30) | fr;
    endfunction

    function automatic t_log_tab f_build_log();
        t_log_tab tab;
        logic [63:0] lg;
        logic [63:0] v;
        for (int i = 0; i <= TAB_DEPTH; i++) begin
            lg = f_log2_ratio(64'(TAB_DEPTH) + 64'd9 * 64'(i), 64'(TAB_DEPTH));
            v = (lg * LOG10_2_Q32 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
            tab[i] = (v > 64'(ONE_NORM)) ? ONE_NORM : v[16:0];
        end
        return tab;
    endfunction

    function automatic t_exp_tab f_build_exp();
        t_exp_tab tab;
        logic [63:0] roots [1:30];
        logic [63:0] x;
        logic [63:0] acc;
        roots[1] = f_isqrt(64'd2 << 60);
        for (int k = 2; k <= 30; k++) roots[k] = f_isqrt(roots[k - 1] << 30);
        for (int i = 0; i <= TAB_DEPTH; i++) begin
            x = (64'(i) << 30) / TAB_DEPTH;
            if (x >= Q30) begin
                tab[i] = 32'h8000_0000;
            end else begin
                acc = Q30;
                for (int k = 1; k <= 30; k++)
                    if (x[30 - k]) acc = (acc * roots[k]) >> 30;
                tab[i] = acc[31:0];
            end
        end
        return tab;
    endfunction

    function automatic t_expk_tab f_build_expk();
        t_expk_tab tab;
        t_desc d;
        logic [63:0] k;
        for (int s = 0; s < ROM_SLOTS; s++) begin
            d = f_desc(6'(s));
            k = (d.taper == TAPER_EXP) ? f_log2_ratio(64'(d.hi), 64'(d.lo)) : 64'd0;
            tab[s] = k[35:0];
        end
        return tab;
    endfunction

    function automatic t_cc_tab f_build_cc();
        t_cc_tab tab;
        logic [63:0] v;
        for (int i = 0; i < 128; i++) begin
            v = (64'(i) * 64'(ONE_NORM) + 64'd63) / 127;
            tab[i] = v[16:0];
        end
        return tab;
    endfunction

    localparam t_log_tab  LOG_TAB = f_build_log();
    localparam t_exp_tab  EXP_TAB = f_build_exp();
    localparam t_expk_tab EXP_K   = f_build_expk();
    localparam t_cc_tab   CC_NORM = f_build_cc();

endpackage
`default_nettype wire

FILE: hdl/pcm_if.sv
`default_nettype none
// Command channel.
interface pcm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [6:0]  cc_number;
    logic [6:0]  cc_value;
    logic [4:0]  param_index;
    logic [16:0] normalized_in;

    modport source (output valid, command, cc_number, cc_value, param_index, normalized_in,
                    input ready);
    modport sink (input valid, command, cc_number, cc_value, param_index, normalized_in,
                  output ready);
endinterface

// Result channel.
interface pcm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] scaled_value;
    logic [16:0] normalized_out;
    logic        hit;
    logic [4:0]  slot_out;

    modport source (output valid, scaled_value, normalized_out, hit, slot_out, input ready);
    modport sink (input valid, scaled_value, normalized_out, hit, slot_out, output ready);
endinterface
`default_nettype wire

FILE: hdl/pcm_store.sv
`default_nettype none
module pcm_store #(
    parameter int NUM_SLOTS = 17,
    parameter int IDX_W     = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr_en,
    input  wire logic [IDX_W-1:0]   i_wr_addr,
    input  wire pcm_pkg::t_norm     i_wr_data,
    input  wire logic               i_rd_en,
    input  wire logic [IDX_W-1:0]   i_rd_addr,
    output pcm_pkg::t_norm          o_rd_data
);
    import pcm_pkg::*;

    t_norm                r_mem [0:NUM_SLOTS-1];
    logic [NUM_SLOTS-1:0] r_written;
    t_norm                r_rd_mem;
    t_norm                r_rd_dflt;
    logic                 r_rd_written;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Track slots that left their reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr_en) begin
            r_written[i_wr_addr] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_mem     <= r_mem[i_rd_addr];
            r_rd_written <= r_written[i_rd_addr];
            r_rd_dflt    <= f_default(6'(i_rd_addr));
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_mem : r_rd_dflt;

endmodule
`default_nettype wire

FILE: hdl/pcm_taper.sv
`default_nettype none
module pcm_taper (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire pcm_pkg::t_slot i_slot,
    input  wire pcm_pkg::t_norm i_t,
    output logic                o_done,
    output pcm_pkg::t_q16       o_value
);
    import pcm_pkg::*;

    t_desc       desc;
    logic [8:0]  li_a;
    logic [8:0]  li_b;
    logic [16:0] lg_a;
    logic [16:0] lg_b;
    logic [16:0] lg_diff;
    logic [32:0] lg_prod;
    logic [16:0] lg_tt;
    logic [33:0] sq_prod;
    logic [35:0] k_sel;
    logic [52:0] y_prod;
    logic [16:0] n_tt;

    logic [3:0]  r_vld;
    t_desc       r1_desc;
    logic [16:0] r1_tt;
    logic [6:0]  r1_ip;
    logic [15:0] r1_fr;

    logic [31:0] span;
    logic [48:0] lin_prod;
    logic [33:0] lin_sum;
    logic [8:0]  ei_a;
    logic [8:0]  ei_b;
    logic [31:0] ex_a;
    logic [31:0] ex_b;
    logic [31:0] ex_diff;
    logic [47:0] ex_prod;
    logic [31:0] ex_e;

    t_desc       r2_desc;
    logic [31:0] r2_lin;
    logic [31:0] r2_e;
    logic [6:0]  r2_ip;

    logic [63:0] v_prod;
    t_desc       r3_desc;
    logic [31:0] r3_lin;
    logic [33:0] r3_v;
    logic [6:0]  r3_ip;

    logic [64:0] ex_shift;
    logic [31:0] ex_out;
    logic [31:0] r4_value;

    // Stage 1: shape t by the taper (log table, square, exponent argument)
    always_comb begin
        desc    = f_desc(i_slot);
        li_a    = {1'b0, i_t[15:8]};
        li_b    = li_a + 9'd1;
        lg_a    = LOG_TAB[li_a];
        lg_b    = LOG_TAB[li_b];
        lg_diff = (lg_b >= lg_a) ? (lg_b - lg_a) : (lg_a - lg_b);
        lg_prod = lg_diff * {i_t[7:0], 8'h00};
        if (i_t[16]) begin
            lg_tt = LOG_TAB[TAB_DEPTH];
        end else if (lg_b >= lg_a) begin
            lg_tt = lg_a + lg_prod[32:16];
        end else begin
            lg_tt = lg_a - lg_prod[32:16];
        end
        sq_prod = i_t * i_t;
        k_sel   = (i_slot < 6'(ROM_SLOTS)) ? EXP_K[i_slot[4:0]] : 36'd0;
        y_prod  = i_t * k_sel;
        case (desc.taper)
            TAPER_LOG: n_tt = lg_tt;
            TAPER_SQ:  n_tt = sq_prod[32:16];
            default:   n_tt = i_t;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_desc <= desc;
        r1_tt   <= n_tt;
        r1_ip   <= y_prod[52:46];
        r1_fr   <= y_prod[45:30];
    end

    // Stage 2: linear span for the min/max tapers, 2^frac for the exponential one
    always_comb begin
        span     = (r1_desc.hi >= r1_desc.lo) ? (r1_desc.hi - r1_desc.lo) : 32'd0;
        lin_prod = r1_tt * span;
        lin_sum  = {2'b00, r1_desc.lo} + {1'b0, lin_prod[48:16]};
        ei_a     = {1'b0, r1_fr[15:8]};
        ei_b     = ei_a + 9'd1;
        ex_a     = EXP_TAB[ei_a];
        ex_b     = EXP_TAB[ei_b];
        ex_diff  = (ex_b >= ex_a) ? (ex_b - ex_a) : (ex_a - ex_b);
        ex_prod  = ex_diff * {r1_fr[7:0], 8'h00};
        ex_e     = (ex_b >= ex_a) ? (ex_a + ex_prod[47:16]) : (ex_a - ex_prod[47:16]);
    end

    always_ff @(posedge i_clk) begin
        r2_desc <= r1_desc;
        r2_lin  <= (lin_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : lin_sum[31:0];
        r2_e    <= ex_e;
        r2_ip   <= r1_ip;
    end

    // Stage 3: scale min by 2^frac
    assign v_prod = r2_desc.lo * r2_e;

    always_ff @(posedge i_clk) begin
        r3_desc <= r2_desc;
        r3_lin  <= r2_lin;
        r3_v    <= v_prod[63:30];
        r3_ip   <= r2_ip;
    end

    // Stage 4: shift by the integer part of the exponent, saturate
    always_comb begin
        ex_shift = {31'd0, r3_v} << r3_ip[4:0];
        if (r3_ip >= 7'd32) begin
            ex_out = (r3_v != 34'd0) ? 32'hFFFF_FFFF : 32'd0;
        end else if (ex_shift[64:32] != 33'd0) begin
            ex_out = 32'hFFFF_FFFF;
        end else begin
            ex_out = ex_shift[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r4_value <= (r3_desc.taper == TAPER_EXP) ? ex_out : r3_lin;
    end

    assign o_done  = r_vld[3];
    assign o_value = r4_value;

endmodule
`default_nettype wire

FILE: hdl/midi_cc_parameter_curve_map.sv
// MIDI controller to parameter map with taper curves.
// Command channel i_in (valid/ready) carries one command per transfer: control
// change, set normalized, read scaled or read normalized. Result channel o_out
// (valid/ready) returns exactly one result per command.
// Parameters live in a 17-bit wide synchronous store with a registered read; the
// taper curves run through a four-stage arithmetic pipeline.
// A control change, a set or a read of an out-of-range index goes straight to
// the output step; a read normalized first waits for the store read, and a read
// scaled then also runs the taper pipeline. One command is in flight at a
// time; the next command is taken once the current one has handed its result
// to the output register.
// Reset clears the written flags of the store, so every slot reads its fixed
// default until first written; no clearing pass is needed.
// While the receiver stalls, the result holds in the output register; at most
// one more command is taken, and it waits in S_OUT with i_in.ready low.
`default_nettype none
`include "midi_cc_parameter_curve_map_macros.svh"
module midi_cc_parameter_curve_map #(
    parameter int NUM_SLOTS = 17
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pcm_in_if.sink     i_in,
    pcm_out_if.source  o_out
);
    import pcm_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [6:0] NSLOT = 7'(NUM_SLOTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_TAPER = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]  r_state;
    logic [1:0]  r_cmd;
    t_slot       r_slot;
    logic [31:0] r_res_scaled;
    t_norm       r_res_norm;
    logic        r_res_hit;
    logic [4:0]  r_res_slot;

    logic        r_out_valid;
    logic [31:0] r_out_scaled;
    t_norm       r_out_norm;
    logic        r_out_hit;
    logic [4:0]  r_out_slot;

    logic        accept;
    t_slot       cc_e;
    t_slot       cc_slot;
    logic        cc_ok;
    logic        idx_ok;
    t_norm       clamp;
    logic        wr_en;
    t_slot       wr_slot;
    t_norm       wr_data;
    logic        rd_en;
    t_norm       rd_data;
    logic        out_free;
    logic        taper_start;
    logic        taper_done;
    logic [31:0] taper_value;

    // Decode the incoming command
    always_comb begin
        accept  = i_in.valid && i_in.ready;
        cc_e    = f_cc_map(i_in.cc_number);
        cc_slot = cc_e - 6'd1;
        cc_ok   = (cc_e != 6'd0) && ({1'b0, cc_slot} < NSLOT);
        idx_ok  = {2'b00, i_in.param_index} < NSLOT;
        clamp   = (i_in.normalized_in > ONE_NORM) ? ONE_NORM : i_in.normalized_in;
        wr_en   = accept && (((i_in.command == CMD_CC) && cc_ok) ||
                             ((i_in.command == CMD_SET) && idx_ok));
        wr_slot = (i_in.command == CMD_CC) ? cc_slot : {1'b0, i_in.param_index};
        wr_data = (i_in.command == CMD_CC) ? CC_NORM[i_in.cc_value] : clamp;
        rd_en   = accept && idx_ok &&
                  ((i_in.command == CMD_RDS) || (i_in.command == CMD_RDN));
        out_free    = !r_out_valid || o_out.ready;
        taper_start = (r_state == S_READ) && (r_cmd == CMD_RDS);
    end

    assign i_in.ready = (r_state == S_IDLE);

    pcm_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_slot[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (wr_slot[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    pcm_taper u_taper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (taper_start),
        .i_slot  (r_slot),
        .i_t     (rd_data),
        .o_done  (taper_done),
        .o_value (taper_value)
    );

    // Command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= rd_en ? S_READ : S_OUT;
                    end
                end
                S_READ:  r_state <= (r_cmd == CMD_RDS) ? S_TAPER : S_OUT;
                S_TAPER: begin
                    if (taper_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Build the result as the command advances
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_cmd        <= i_in.command;
                    r_slot       <= {1'b0, i_in.param_index};
                    r_res_scaled <= '0;
                    if (i_in.command == CMD_CC) begin
                        r_res_norm <= cc_ok ? wr_data : '0;
                        r_res_hit  <= cc_ok;
                        r_res_slot <= cc_ok ? cc_slot[4:0] : 5'd0;
                    end else begin
                        r_res_norm <= ((i_in.command == CMD_SET) && idx_ok) ? clamp : '0;
                        r_res_hit  <= idx_ok;
                        r_res_slot <= i_in.param_index;
                    end
                end
            end
            S_READ:  r_res_norm <= rd_data;
            S_TAPER: begin
                if (taper_done) begin
                    r_res_scaled <= taper_value;
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_scaled <= r_res_scaled;
            r_out_norm   <= r_res_norm;
            r_out_hit    <= r_res_hit;
            r_out_slot   <= r_res_slot;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.scaled_value   = r_out_scaled;
    assign o_out.normalized_out = r_out_norm;
    assign o_out.hit            = r_out_hit;
    assign o_out.slot_out       = r_out_slot;

    `PCM_ASSERT_NOW(a_miss_zero, r_out_valid && !r_out_hit, r_out_norm == '0, "miss with value")
    `PCM_ASSERT_NOW(a_scaled_hit, r_out_valid && (|r_out_scaled), r_out_hit, "scaled without hit")
    `PCM_ASSERT_NOW(a_done_in_taper, taper_done, r_state == S_TAPER, "taper result outside wait")
    `PCM_ASSERT_NEXT(a_accept_leaves_idle, accept, r_state != S_IDLE, "sequencer stayed idle")

endmodule
`default_nettype wire

FILE: test/tb.sv
`default_nettype none
module tb;
    import pcm_pkg::*;

    typedef struct {
        logic [1:0]  command;
        logic [6:0]  cc_number;
        logic [6:0]  cc_value;
        logic [4:0]  param_index;
        logic [16:0] normalized_in;
    } t_cmd;

    typedef struct {
        logic [31:0] scaled_value;
        logic [16:0] normalized_out;
        logic        hit;
        logic [4:0]  slot_out;
    } t_result;

    typedef longint unsigned t_u64;

    localparam int NSLOT = 17;
    localparam int DEPTH = 256;
    localparam t_u64 ONE = 64'd65536;
    localparam t_u64 Q30_ONE = 64'd1 << 30;
    localparam t_u64 SAT = 64'hFFFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    pcm_in_if  cmd_if ();
    pcm_out_if res_if ();

    midi_cc_parameter_curve_map u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_if),
        .o_out  (res_if)
    );

    // Taper descriptors and defaults of the block
    t_u64     slot_lo    [0:NSLOT-1] = '{0, 100 << 16, 0, 3277, 6554, 65536, 20 << 16, 0, 6554,
                                         0, 0, 0, 200 << 16, 0, 65536, 0, 0};
    t_u64     slot_hi    [0:NSLOT-1] = '{65536, 20000 << 16, 32768, 32768, 2000 << 16,
                                         5000 << 16, 18000 << 16, 65536, 5 << 16, 2 << 16,
                                         65536, 65536, 12000 << 16, 65536, 1000 << 16,
                                         62259, 65536};
    logic [1:0] slot_taper [0:NSLOT-1] = '{TAPER_SQ, TAPER_LOG, TAPER_LIN, TAPER_LIN,
                                         TAPER_LOG, TAPER_LOG, TAPER_EXP, TAPER_LIN,
                                         TAPER_LOG, TAPER_LIN, TAPER_LIN, TAPER_LIN,
                                         TAPER_EXP, TAPER_LIN, TAPER_SQ, TAPER_LIN,
                                         TAPER_LIN};
    logic [16:0] slot_default [0:NSLOT-1] = '{65536, 7130, 26214, 21845, 0, 340, 57723,
                                         32768, 3833, 32768, 0, 58982, 51523, 32768,
                                         20631, 34493, 16384};

    t_u64        log_curve [0:DEPTH];
    t_u64        pow2_curve [0:DEPTH];
    t_u64        exp_slope [0:NSLOT-1];
    logic [16:0] param_mirror [0:NSLOT-1];

    t_result pending_results[$];
    int      err_count;
    int      tx_idle;
    int      rx_idle;
    int      hold_requests;
    int      hold_served;
    int      hold_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_u64 int_sqrt(input t_u64 v_in);
        t_u64 v;
        t_u64 res;
        t_u64 b;
        v = v_in;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // log2(n/d) in Q.30 by repeated squaring
    function automatic t_u64 log2_of_ratio(input t_u64 n, input t_u64 d_in);
        t_u64 d;
        t_u64 ip;
        t_u64 fr;
        t_u64 m;
        d = d_in;
        ip = 0;
        fr = 0;
        if (d == 0 || n < d) return 0;
        while (n >= 2 * d) begin
            d = d << 1;
            ip++;
        end
        m = (n << 30) / d;
        for (int k = 29; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= 2 * Q30_ONE) begin
                m = m >> 1;
                fr |= 64'd1 << k;
            end
        end
        return (ip << 30) | fr;
    endfunction

    function automatic void build_curves();
        t_u64 roots [1:30];
        t_u64 lg;
        t_u64 v;
        t_u64 x;
        t_u64 acc;
        roots[1] = int_sqrt(64'd2 << 60);
        for (int k = 2; k <= 30; k++) roots[k] = int_sqrt(roots[k - 1] << 30);
        for (int i = 0; i <= DEPTH; i++) begin
            lg = log2_of_ratio(DEPTH + 9 * i, DEPTH);
            v = (lg * 64'd1292913986 + (64'd1 << 45)) >> 46;
            log_curve[i] = (v > ONE) ? ONE : v;
            x = (t_u64'(i) << 30) / DEPTH;
            if (x >= Q30_ONE) begin
                pow2_curve[i] = 2 * Q30_ONE;
            end else begin
                acc = Q30_ONE;
                for (int k = 1; k <= 30; k++)
                    if ((x >> (30 - k)) & 1) acc = (acc * roots[k]) >> 30;
                pow2_curve[i] = acc;
            end
        end
        for (int s = 0; s < NSLOT; s++)
            exp_slope[s] = (slot_taper[s] == TAPER_EXP) ?
                           log2_of_ratio(slot_hi[s], slot_lo[s]) : 0;
    endfunction

    // Linear interpolation between curve points, truncating
    function automatic t_u64 curve_at(input bit use_pow2, input t_u64 t);
        t_u64 pos;
        t_u64 i;
        t_u64 fr;
        t_u64 a;
        t_u64 b;
        pos = t * DEPTH;
        i = pos >> 16;
        fr = pos & (ONE - 1);
        if (i >= DEPTH) return use_pow2 ? pow2_curve[DEPTH] : log_curve[DEPTH];
        a = use_pow2 ? pow2_curve[i] : log_curve[i];
        b = use_pow2 ? pow2_curve[i + 1] : log_curve[i + 1];
        if (b >= a) return a + (((b - a) * fr) >> 16);
        return a - (((a - b) * fr) >> 16);
    endfunction

    function automatic t_u64 taper_value(input int s, input t_u64 t);
        t_u64 tt;
        t_u64 span;
        t_u64 v;
        t_u64 y;
        t_u64 ip;
        tt = t;
        if (slot_taper[s] == TAPER_EXP) begin
            y = t * exp_slope[s];
            ip = y >> 46;
            v = (slot_lo[s] * curve_at(1'b1, (y >> 30) & (ONE - 1))) >> 30;
            if (ip >= 32) return (v != 0) ? SAT : 0;
            if (v > (SAT >> ip)) return SAT;
            return v << ip;
        end
        if (slot_taper[s] == TAPER_LOG) tt = curve_at(1'b0, t);
        else if (slot_taper[s] == TAPER_SQ) tt = (t * t) >> 16;
        span = (slot_hi[s] >= slot_lo[s]) ? slot_hi[s] - slot_lo[s] : 0;
        v = slot_lo[s] + ((tt * span) >> 16);
        return (v > SAT) ? SAT : v;
    endfunction

    function automatic int cc_to_slot(input logic [6:0] n);
        case (n)
            7'd1:  return 16;
            7'd25: return 14;
            7'd26: return 11;
            7'd27: return 12;
            7'd28: return 13;
            7'd29: return 15;
            default: return (n >= 14 && n <= 24) ? n - 14 : -1;
        endcase
    endfunction

    // Work out the result of one command and update the mirrored store
    function automatic t_result apply_command(input t_cmd c);
        t_result r;
        int s;
        t_u64 v;
        r = '{32'd0, 17'd0, 1'b0, 5'd0};
        if (c.command == CMD_CC) begin
            s = cc_to_slot(c.cc_number);
            if (s >= 0) begin
                v = (t_u64'(c.cc_value) * ONE + 63) / 127;
                param_mirror[s] = v[16:0];
                r.normalized_out = v[16:0];
                r.hit = 1'b1;
                r.slot_out = s[4:0];
            end
        end else begin
            r.slot_out = c.param_index;
            if (c.param_index < NSLOT) begin
                r.hit = 1'b1;
                if (c.command == CMD_SET)
                    param_mirror[c.param_index] = (c.normalized_in > ONE) ?
                                                  17'(ONE) : c.normalized_in;
                r.normalized_out = param_mirror[c.param_index];
                if (c.command == CMD_RDS)
                    r.scaled_value = 32'(taper_value(c.param_index, r.normalized_out));
            end
        end
        return r;
    endfunction

    // Offer one command, hold it until the transfer, then record its result
    task automatic send_cmd(input t_cmd c);
        while ($urandom_range(0, 99) < tx_idle) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.command       <= c.command;
        cmd_if.cc_number     <= c.cc_number;
        cmd_if.cc_value      <= c.cc_value;
        cmd_if.param_index   <= c.param_index;
        cmd_if.normalized_in <= c.normalized_in;
        do @(posedge i_clk); while (!cmd_if.ready);
        pending_results = {pending_results, apply_command(c)};
    endtask

    task automatic send_fields(input logic [1:0] cmd, input logic [6:0] ccn,
                               input logic [6:0] ccv, input logic [4:0] idx,
                               input logic [16:0] nin);
        t_cmd c;
        c = '{cmd, ccn, ccv, idx, nin};
        send_cmd(c);
    endtask

    function automatic t_cmd random_cmd();
        t_cmd c;
        int pick;
        c.command = 2'($urandom_range(0, 3));
        c.cc_value = 7'($urandom);
        c.normalized_in = 17'($urandom);
        pick = $urandom_range(0, 9);
        c.cc_number = (pick < 7) ? 7'($urandom_range(13, 30)) :
                      (pick < 8) ? 7'd1 : 7'($urandom);
        c.param_index = (pick < 8) ? 5'($urandom_range(0, NSLOT - 1)) : 5'($urandom);
        if ($urandom_range(0, 3) == 0) c.normalized_in = 17'($urandom_range(0, 65536));
        return c;
    endfunction

    // Receiver ready: random stalls plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_left <= 0;
            hold_served <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= 300;
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // Compare each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_if.scaled_value !== want.scaled_value) begin
                    $error("scaled_value: expected %0d, got %0d",
                           want.scaled_value, res_if.scaled_value);
                    err_count++;
                end
                if (res_if.normalized_out !== want.normalized_out) begin
                    $error("normalized_out: expected %0d, got %0d",
                           want.normalized_out, res_if.normalized_out);
                    err_count++;
                end
                if (res_if.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, res_if.hit);
                    err_count++;
                end
                if (res_if.slot_out !== want.slot_out) begin
                    $error("slot_out: expected %0d, got %0d", want.slot_out, res_if.slot_out);
                    err_count++;
                end
            end
        end
    end

    task automatic test_directed();
        // Defaults through every taper
        for (int s = 0; s < NSLOT; s++) send_fields(CMD_RDS, 7'd0, 7'd0, 5'(s), 17'd0);
        send_fields(CMD_CC, 7'd0, 7'd127, 5'd31, 17'h1FFFF);
        send_fields(CMD_CC, 7'd127, 7'd5, 5'd0, 17'd0);
        send_fields(CMD_CC, 7'd1, 7'd127, 5'd0, 17'd0);
        send_fields(CMD_CC, 7'd14, 7'd0, 5'd0, 17'd0);
        send_fields(CMD_SET, 7'd0, 7'd0, 5'd0, 17'h1FFFF);
        send_fields(CMD_SET, 7'd0, 7'd0, 5'd12, 17'd0);
        send_fields(CMD_RDS, 7'd0, 7'd0, 5'd12, 17'd0);
        send_fields(CMD_SET, 7'd0, 7'd0, 5'd31, 17'd65536);
        send_fields(CMD_RDN, 7'd0, 7'd0, 5'd17, 17'd0);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) send_cmd(random_cmd());
    endtask

    // Stall the receiver long enough to back up the command channel
    task automatic test_backpressure();
        tx_idle = 0;
        hold_requests++;
        test_random(30);
    endtask

    initial begin
        err_count = 0;
        tx_idle = 0;
        rx_idle = 0;
        hold_requests = 0;
        i_rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_CC;
        cmd_if.cc_number = '0;
        cmd_if.cc_value = '0;
        cmd_if.param_index = '0;
        cmd_if.normalized_in = '0;
        build_curves();
        for (int s = 0; s < NSLOT; s++) param_mirror[s] = slot_default[s];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle = 18;
        rx_idle = 65;
        test_directed();
        test_random(580);
        tx_idle = 65;
        rx_idle = 18;
        test_random(580);
        tx_idle = 0;
        rx_idle = 0;
        test_random(580);
        test_backpressure();
        cmd_if.valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
